// ----- src/prtt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package prtt_pkg;

  // Field and register widths.
  localparam int unsigned SeqW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SumW   = 64;

  // The average divider retires one quotient bit per cycle.
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Register reset values.
  localparam logic [CfgW-1:0] IntervalRst = 16'd1000;
  localparam logic [CfgW-1:0] TimeoutRst  = 16'd200;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CfgPingInterval = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgReplyTimeout = 2'd1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_STAT,
    ST_LAUNCH,
    ST_DIV,
    ST_WB
  } state_e;

  // One tick item.
  typedef struct packed {
    logic            pong_valid;
    logic [SeqW-1:0] pong_seq;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic             ping_sent;
    logic [SeqW-1:0]  ping_seq_out;
    logic             pong_matched;
    logic [TimeW-1:0] rtt_ms;
    logic             timed_out;
    logic [TimeW-1:0] rtt_min_ms;
    logic [TimeW-1:0] rtt_max_ms;
    logic [TimeW-1:0] rtt_avg_ms;
    logic [TimeW-1:0] reply_total;
    logic [TimeW-1:0] lost_total;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/prtt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module prtt_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [prtt_pkg::SumW-1:0]     dividend_i,
  input  wire logic [prtt_pkg::TimeW-1:0]    divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [prtt_pkg::TimeW-1:0]         quot_o
);
  import prtt_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [SumW-1:0]    nq_q;
  logic [TimeW-1:0]   rem_q;
  logic [TimeW-1:0]   dvs_q;
  logic [TimeW:0]     rem_sh;
  logic [TimeW:0]     rem_sub;
  logic               q_bit;

  // Restoring step: shift in the next dividend bit and try the subtract.
  assign rem_sh  = {rem_q, nq_q[SumW-1]};
  assign q_bit   = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = q_bit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  // Control: busy while the quotient bits are retired, then a done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      nq_q  <= {nq_q[SumW-2:0], q_bit};
      rem_q <= rem_sub[TimeW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = nq_q[TimeW-1:0];

`ifndef SYNTH
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");
  a_done_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider still busy after done");
`endif

endmodule

`default_nettype wire

// ----- src/ping_rtt_monitor_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ping round-trip monitor. Each input item is one millisecond tick that may
// carry a received pong; each tick yields exactly one result item with the
// ping/pong events of that tick and the running min, max, average, reply and
// loss totals. While at least one reply has been counted, an item passes
// through accept, evaluate, statistics, divider launch, 64 divider steps,
// the divider done pulse and write-back, which loads its result into the
// output register. While the reply count is zero the divider is skipped.
// The bit-serial 64-by-32 divider forms the average one quotient bit per
// cycle. Write-back waits while an earlier result is still stalled in the
// output register. A new item is taken once the previous result sits in
// the output register, even if it is still stalled.
// The two interval and timeout registers may be written at any time the
// block is idle.
module ping_rtt_monitor_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [prtt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [prtt_pkg::CfgW-1:0]       cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire prtt_pkg::in_item_t              in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output prtt_pkg::out_item_t                  out_item_o
);
  import prtt_pkg::*;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CfgW-1:0] interval_q;
  logic [CfgW-1:0] timeout_q;

  // Probe state.
  logic [TimeW-1:0] tick_q;
  logic [SeqW-1:0]  seq_q;
  logic [TimeW-1:0] sent_at_q;
  logic             await_q;
  logic [TimeW-1:0] min_q;
  logic [TimeW-1:0] max_q;
  logic [SumW-1:0]  sum_q;
  logic [TimeW-1:0] reply_cnt_q;
  logic [TimeW-1:0] lost_cnt_q;

  // Per-item working registers.
  logic             pv_q;
  logic [SeqW-1:0]  pseq_q;
  logic [TimeW-1:0] elap_q;
  logic             matched_q;
  logic             sent_q;
  logic             lost_q;
  logic [TimeW-1:0] rtt_q;
  logic [TimeW-1:0] avg_q;

  // Output register.
  logic      out_valid_q;
  out_item_t out_item_q;

  // Sequencer decodes.
  logic accept;
  logic div_start;
  logic wb_load;
  logic div_busy;
  logic div_done;
  logic [TimeW-1:0] div_quot;

  // Tick decisions; the send and loss checks use the elapsed time latched at acceptance.
  logic match_w;
  logic wait_left;
  logic send_w;
  logic lost_w;

  assign match_w   = pv_q && await_q && (pseq_q == seq_q);
  assign wait_left = await_q && !match_w;
  assign send_w    = !wait_left && (elap_q >= {{(TimeW-CfgW){1'b0}}, interval_q});
  assign lost_w    = wait_left && (elap_q > {{(TimeW-CfgW){1'b0}}, timeout_q});

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and sequencer strobes.
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    div_start  = 1'b0;
    wb_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          accept  = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_STAT;
      end
      ST_STAT: begin
        state_d = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        if (reply_cnt_q != '0) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_WB;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (!out_valid_q || !out_stall_i) begin
          wb_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Configuration writes; indexes past the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalRst;
      timeout_q  <= TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPingInterval: interval_q <= cfg_data_i;
        CfgReplyTimeout: timeout_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Probe state updates in the evaluate and statistics states.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      seq_q       <= '0;
      sent_at_q   <= '0;
      await_q     <= 1'b0;
      min_q       <= '1;
      max_q       <= '0;
      sum_q       <= '0;
      reply_cnt_q <= '0;
      lost_cnt_q  <= '0;
    end else begin
      if (state_q == ST_EVAL) begin
        tick_q  <= tick_q + 1'b1;
        await_q <= send_w || (wait_left && !lost_w);
        if (match_w || lost_w) begin
          seq_q <= seq_q + 1'b1;
        end
        if (send_w) begin
          sent_at_q <= tick_q;
        end else if (lost_w) begin
          sent_at_q <= tick_q - {{(TimeW-CfgW){1'b0}}, interval_q};
        end
        if (match_w) begin
          reply_cnt_q <= reply_cnt_q + 1'b1;
        end
        if (lost_w) begin
          lost_cnt_q <= lost_cnt_q + 1'b1;
        end
      end
      if (state_q == ST_STAT && matched_q) begin
        if (rtt_q < min_q) begin
          min_q <= rtt_q;
        end
        if (rtt_q > max_q) begin
          max_q <= rtt_q;
        end
        sum_q <= sum_q + {{(SumW-TimeW){1'b0}}, rtt_q};
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pv_q   <= in_item_i.pong_valid;
      pseq_q <= in_item_i.pong_seq;
      elap_q <= tick_q - sent_at_q;
    end
    if (state_q == ST_EVAL) begin
      matched_q <= match_w;
      sent_q    <= send_w;
      lost_q    <= lost_w;
      rtt_q     <= match_w ? elap_q : '0;
    end
    if (state_q == ST_LAUNCH) begin
      avg_q <= '0;
    end else if (state_q == ST_DIV && div_done) begin
      avg_q <= div_quot;
    end
  end

  // Iterative divider for the running average.
  prtt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (reply_cnt_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Output register; it frees the input side while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wb_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_load) begin
      out_item_q.ping_sent    <= sent_q;
      out_item_q.ping_seq_out <= seq_q;
      out_item_q.pong_matched <= matched_q;
      out_item_q.rtt_ms       <= rtt_q;
      out_item_q.timed_out    <= lost_q;
      out_item_q.rtt_min_ms   <= min_q;
      out_item_q.rtt_max_ms   <= max_q;
      out_item_q.rtt_avg_ms   <= avg_q;
      out_item_q.reply_total  <= reply_cnt_q;
      out_item_q.lost_total   <= lost_cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_div_only_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV))
    else $error("divider running outside the divide step");
  a_events_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_item_q.timed_out && (out_item_q.ping_sent ||
                                               out_item_q.pong_matched)))
    else $error("timeout reported together with a send or a match");
  a_rtt_only_on_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_item_q.pong_matched) |-> (out_item_q.rtt_ms == '0))
    else $error("round-trip time reported without a matched pong");
  a_one_item_at_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EVAL))
    else $error("accepted item did not enter evaluation");
`endif

endmodule

`default_nettype wire

// ----- tb/ping_rtt_monitor_core_test.sv -----
`timescale 1ns / 1ps

module ping_rtt_monitor_core_test;
  import prtt_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 100;
  localparam int PressureHold = 400;
  localparam int MaxPrinted = 60;

  // Spare register indexes that the block must ignore.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  // Two copies of the probe state: one steers generation, one checks the block.
  localparam int PlanSt = 0;
  localparam int CheckSt = 1;

  typedef struct packed {
    logic [TimeW-1:0] tick;
    logic [TimeW-1:0] sent_at;
    logic [SeqW-1:0]  seq;
    logic             pending;
    logic [TimeW-1:0] rtt_lo;
    logic [TimeW-1:0] rtt_hi;
    logic [SumW-1:0]  rtt_sum;
    logic [TimeW-1:0] replies;
    logic [TimeW-1:0] losses;
  } probe_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;

  ping_rtt_monitor_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  logic [CfgW-1:0] ping_interval = IntervalRst;
  logic [CfgW-1:0] reply_timeout = TimeoutRst;
  probe_state_t probe_st [2];

  in_item_t tick_q[$];
  out_item_t expected_ticks[$];
  int ticks_queued = 0;
  int ticks_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int settings_count = 0;
  int pings_seen = 0;
  int replies_seen = 0;
  int losses_seen = 0;

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance one copy of the probe state by one millisecond tick.
  function automatic out_item_t probe_tick(input int which, input in_item_t it);
    probe_state_t st;
    out_item_t r;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] elapsed;
    logic [SumW-1:0] quot;
    st = probe_st[which];
    r = '0;
    now = st.tick;
    // A pong counts only if it carries the sequence of the pending ping.
    if (it.pong_valid && st.pending && it.pong_seq == st.seq) begin
      r.pong_matched = 1'b1;
      r.rtt_ms = now - st.sent_at;
      st.pending = 1'b0;
      st.seq = st.seq + 1'b1;
      if (r.rtt_ms < st.rtt_lo) st.rtt_lo = r.rtt_ms;
      if (r.rtt_ms > st.rtt_hi) st.rtt_hi = r.rtt_ms;
      st.rtt_sum = st.rtt_sum + {32'd0, r.rtt_ms};
      st.replies = st.replies + 1'b1;
    end
    // Send once the interval since the last send has run out.
    elapsed = now - st.sent_at;
    if (!st.pending && elapsed >= {16'd0, ping_interval}) begin
      r.ping_sent = 1'b1;
      st.sent_at = now;
      st.pending = 1'b1;
    end
    // A loss backdates the send time so the next ping leaves on the next tick.
    elapsed = now - st.sent_at;
    if (st.pending && elapsed > {16'd0, reply_timeout}) begin
      r.timed_out = 1'b1;
      st.losses = st.losses + 1'b1;
      st.pending = 1'b0;
      st.seq = st.seq + 1'b1;
      st.sent_at = now - {16'd0, ping_interval};
    end
    st.tick = now + 1'b1;
    r.ping_seq_out = st.seq;
    r.rtt_min_ms = st.rtt_lo;
    r.rtt_max_ms = st.rtt_hi;
    if (st.replies != 0) begin
      quot = st.rtt_sum / {32'd0, st.replies};
      r.rtt_avg_ms = quot[TimeW-1:0];
    end
    r.reply_total = st.replies;
    r.lost_total = st.losses;
    probe_st[which] = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [SumW-1:0] got_v,
                                 input logic [SumW-1:0] want_v);
    if (mismatches < MaxPrinted)
      $display("mismatch at result %0d: %s is %0h, expected %0h",
               results_seen, what, got_v, want_v);
    mismatches++;
  endtask

  // Queue one tick item and advance the generation copy of the state.
  task automatic queue_tick(input logic valid, input logic [SeqW-1:0] seq);
    in_item_t it;
    it.pong_valid = valid;
    it.pong_seq = seq;
    tick_q.push_back(it);
    void'(probe_tick(PlanSt, it));
    ticks_queued++;
  endtask

  // Now and then a timely pong for the pending ping; otherwise no pong, a stray or a late pong.
  task automatic random_tick(input int odds);
    logic [SeqW-1:0] cur;
    cur = probe_st[PlanSt].seq;
    if (probe_st[PlanSt].pending && $urandom_range(1, odds) == 1) begin
      queue_tick(1'b1, cur);
    end else begin
      case ($urandom_range(0, 3))
        0, 1: queue_tick(1'b0, SeqW'($urandom));
        2: queue_tick(1'b1, cur ^ SeqW'($urandom_range(1, 65535)));
        default: queue_tick(1'b1, probe_st[PlanSt].pending ? cur - 1'b1 : cur);
      endcase
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CfgPingInterval) ping_interval = val;
    else if (idx == CfgReplyTimeout) reply_timeout = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Reprogram both registers once every queued tick has produced its result, now and then also a spare index.
  task automatic apply_setting(input logic [CfgW-1:0] interval, input logic [CfgW-1:0] timeout);
    wait (ticks_queued == results_seen);
    repeat (2) @(negedge clk_i);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CfgPingInterval, interval);
      write_reg(CfgReplyTimeout, timeout);
    end else begin
      write_reg(CfgReplyTimeout, timeout);
      write_reg(CfgPingInterval, interval);
    end
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, CfgW'($urandom));
    settings_count++;
  endtask

  function automatic logic [CfgW-1:0] pick_period();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 16'd1;
      default: return CfgW'($urandom_range(1, 40));
    endcase
  endfunction

  // Input driver: offers queued items with random gaps.
  int tx_gap = 0;
  int ticks_offered = 0;
  bit tx_calm = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && ticks_taken < ticks_offered)) begin
      if (tx_gap != 0) begin
        in_valid_i <= 1'b0;
        tx_gap = tx_gap - 1;
      end else if (tick_q.size() != 0) begin
        in_item_i <= tick_q.pop_front();
        in_valid_i <= 1'b1;
        ticks_offered = ticks_offered + 1;
        if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall control, with a long hold-off now and then to fill the block.
  int rx_wait = 0;
  int rx_hold = 0;
  int rx_drawn = 0;
  bit rx_calm = 1'b0;
  always @(negedge clk_i) begin
    if (rx_drawn != results_seen) begin
      rx_drawn = results_seen;
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 9);
      if (results_seen == 300 || results_seen == 800) rx_hold = PressureHold;
    end
    if (rx_hold != 0) begin
      out_stall_i <= 1'b1;
      rx_hold = rx_hold - 1;
    end else if (out_valid_o && rx_wait != 0) begin
      out_stall_i <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Handshake tracking: predict accepted items and check accepted results.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_ticks.push_back(probe_tick(CheckSt, in_item_i));
      ticks_taken <= ticks_taken + 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        want = expected_ticks.pop_front();
        if (out_item_o.ping_sent !== want.ping_sent)
          report_mismatch("ping_sent", SumW'(out_item_o.ping_sent), SumW'(want.ping_sent));
        if (out_item_o.ping_seq_out !== want.ping_seq_out)
          report_mismatch("ping_seq_out", SumW'(out_item_o.ping_seq_out),
                          SumW'(want.ping_seq_out));
        if (out_item_o.pong_matched !== want.pong_matched)
          report_mismatch("pong_matched", SumW'(out_item_o.pong_matched),
                          SumW'(want.pong_matched));
        if (out_item_o.rtt_ms !== want.rtt_ms)
          report_mismatch("rtt_ms", SumW'(out_item_o.rtt_ms), SumW'(want.rtt_ms));
        if (out_item_o.timed_out !== want.timed_out)
          report_mismatch("timed_out", SumW'(out_item_o.timed_out), SumW'(want.timed_out));
        if (out_item_o.rtt_min_ms !== want.rtt_min_ms)
          report_mismatch("rtt_min_ms", SumW'(out_item_o.rtt_min_ms),
                          SumW'(want.rtt_min_ms));
        if (out_item_o.rtt_max_ms !== want.rtt_max_ms)
          report_mismatch("rtt_max_ms", SumW'(out_item_o.rtt_max_ms),
                          SumW'(want.rtt_max_ms));
        if (out_item_o.rtt_avg_ms !== want.rtt_avg_ms)
          report_mismatch("rtt_avg_ms", SumW'(out_item_o.rtt_avg_ms),
                          SumW'(want.rtt_avg_ms));
        if (out_item_o.reply_total !== want.reply_total)
          report_mismatch("reply_total", SumW'(out_item_o.reply_total),
                          SumW'(want.reply_total));
        if (out_item_o.lost_total !== want.lost_total)
          report_mismatch("lost_total", SumW'(out_item_o.lost_total),
                          SumW'(want.lost_total));
        pings_seen += int'(want.ping_sent);
        replies_seen += int'(want.pong_matched);
        losses_seen += int'(want.timed_out);
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [SeqW-1:0] cur;
    for (int i = 0; i < 2; i++) begin
      probe_st[i] = '0;
      probe_st[i].rtt_lo = '1;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: pongs while nothing is pending are ignored.
    queue_tick(1'b1, '0);
    queue_tick(1'b0, '1);
    queue_tick(1'b1, '1);

    // Zero interval and zero timeout, plus writes to the spare indexes.
    apply_setting('0, '0);
    write_reg(CfgSpareLo, '1);
    write_reg(CfgSpareHi, 16'h1234);
    queue_tick(1'b0, '0);
    queue_tick(1'b1, probe_st[PlanSt].seq);
    queue_tick(1'b0, '1);
    queue_tick(1'b0, '0);
    queue_tick(1'b1, probe_st[PlanSt].seq);
    queue_tick(1'b1, probe_st[PlanSt].seq ^ 16'h8000);

    // Longest interval with the shortest nonzero timeout.
    apply_setting('1, 16'd1);
    queue_tick(1'b0, '0);
    queue_tick(1'b0, '0);
    queue_tick(1'b0, '0);
    queue_tick(1'b1, probe_st[PlanSt].seq);
    queue_tick(1'b1, probe_st[PlanSt].seq);
    queue_tick(1'b0, '1);

    // Shortest nonzero interval with the longest timeout; stray pongs at both extremes.
    apply_setting(16'd1, '1);
    for (int i = 0; i < 8; i++) begin
      cur = probe_st[PlanSt].seq;
      case (i)
        2: queue_tick(1'b1, ~cur);
        3: queue_tick(1'b1, cur);
        5: queue_tick(1'b1, cur == '1 ? '0 : '1);
        7: queue_tick(1'b1, cur);
        default: queue_tick(1'b0, '0);
      endcase
    end

    // Random settings with mostly well-formed ping and pong traffic.
    for (int p = 0; p < 10; p++) begin
      int odds;
      apply_setting(pick_period(), pick_period());
      odds = $urandom_range(1, 12);
      for (int i = 0; i < 90; i++) random_tick(odds);
    end

    // Late replies under a long timeout stretch the round-trip times.
    apply_setting(16'd3, '1);
    for (int i = 0; i < 300; i++) random_tick(150);

    wait (ticks_queued == results_seen);
    repeat (DrainCycles) @(negedge clk_i);
    if (expected_ticks.size() != 0)
      report_mismatch("results missing", SumW'(expected_ticks.size()), '0);

    $display("Ran %0d ticks over %0d register settings after the reset defaults.",
             results_seen, settings_count);
    $display("Saw %0d pings sent, %0d replies matched and %0d pings lost.",
             pings_seen, replies_seen, losses_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/prtt_pkg.sv
src/prtt_div.sv
src/ping_rtt_monitor_core.sv
tb/ping_rtt_monitor_core_test.sv
